@@ hdl/mbfr_pkg.sv @@
// Package for the MSB-first bit field reader: widths, defaults, command and state types.
package mbfr_pkg;

    localparam int BUF_BYTES_DEF = 4096;
    localparam int MAX_COUNT_DEF = 64;

    localparam int LEN_W  = 13;
    localparam int IDXI_W = 12;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 16;
    localparam int OFF_W  = 16;
    localparam int CNT_W  = 7;
    localparam int VAL_W  = 64;
    localparam int IDX_W  = POS_W - 2;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_SETPOS = 2'd1,
        CMD_SEEK = 2'd2,
        CMD_READ = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_DRAIN
    } t_state;

endpackage

@@ hdl/msb_first_bit_field_reader.sv @@
// MSB-first bit field reader: byte buffer memory, bit position and read sequencer.
//
// Load, set-position and seek commands strobe their result on o_done in the cycle after
// start is taken, and the block can take another command right away.
// A read of n bits at bit offset o within a byte fetches ceil((o + n) / 8) bytes from the
// single-port byte memory, one per cycle, and holds busy through the fetch and then through
// a drain state that takes in the last memory read. A read of zero bits strobes o_done
// in the cycle after start is taken. o_done is high for exactly one cycle per command;
// the receiver has no way to stall it, so the result must be taken when it appears.
// Writing the length clears the bit position; bytes at or past the length read as zero.
module msb_first_bit_field_reader #(
    parameter int BUF_BYTES = mbfr_pkg::BUF_BYTES_DEF,
    parameter int MAX_COUNT = mbfr_pkg::MAX_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [mbfr_pkg::LEN_W-1:0]  i_cfg_wr_data,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [1:0]                  i_cmd,
    input  logic [mbfr_pkg::IDXI_W-1:0] i_byte_index,
    input  logic [mbfr_pkg::BYTE_W-1:0] i_byte_value,
    input  logic [mbfr_pkg::POS_W-1:0]  i_new_position,
    input  logic signed [mbfr_pkg::OFF_W-1:0] i_seek_offset,
    input  logic [mbfr_pkg::CNT_W-1:0]  i_bit_count,
    output logic                        o_done,
    output logic [mbfr_pkg::VAL_W-1:0]  o_read_value,
    output logic [mbfr_pkg::POS_W-1:0]  o_position_now,
    output logic                        o_at_end
);
    import mbfr_pkg::*;

    localparam int AW        = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
    localparam int MAX_BYTES = (MAX_COUNT + 14) / 8;
    localparam int ACC_W     = MAX_BYTES * BYTE_W;
    localparam int NB_W      = $clog2(MAX_BYTES + 1);
    localparam logic [IDX_W-1:0] BUF_LEN = IDX_W'(BUF_BYTES);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COUNT);
    localparam logic [POS_W:0]   POS_SAT = {1'b0, {POS_W{1'b1}}};

    logic [BYTE_W-1:0] mem [BUF_BYTES];

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_len;
    logic [POS_W-1:0]  r_pos;
    logic [IDX_W-1:0]  r_byte_idx;
    logic [NB_W-1:0]   r_left;
    logic [2:0]        r_sh;
    logic [CNT_W-1:0]  r_cnt;
    logic [ACC_W-1:0]  r_acc;
    logic [BYTE_W-1:0] r_rd_data;
    logic              r_rd_ok;
    logic              r_pend;
    logic              r_done;
    logic [VAL_W-1:0]  r_value;
    logic [POS_W-1:0]  r_pos_out;
    logic              r_at_end;

    logic              s_accept, s_issue, s_fin;
    t_cmd              s_cmd;
    logic [IDX_W-1:0]  s_wr_idx;
    logic [IDX_W-1:0]  s_eff;
    logic [POS_W:0]    s_limit;
    logic [CNT_W-1:0]  s_cnt;
    logic [CNT_W:0]    s_span;
    logic [CNT_W+1:0]  s_span_up;
    logic [NB_W-1:0]   s_nb;
    logic              s_idx_ok;
    logic signed [POS_W+1:0] s_seek;
    logic [POS_W-1:0]  s_seek_pos;
    logic [POS_W:0]    s_adv;
    logic [POS_W-1:0]  s_adv_pos;
    logic [ACC_W-1:0]  n_acc;
    logic [ACC_W+VAL_W-1:0] s_wide;
    logic [VAL_W-1:0]  s_mask;
    logic [VAL_W-1:0]  s_rd_value;

    assign s_cmd    = t_cmd'(i_cmd);
    assign s_wr_idx = {2'b00, i_byte_index};
    assign s_eff    = ({1'b0, r_len} > BUF_LEN) ? BUF_LEN : {1'b0, r_len};
    assign s_limit  = {s_eff, 3'b000};

    assign s_cnt     = (i_bit_count > CNT_MAX) ? CNT_MAX : i_bit_count;
    assign s_span    = {5'b0, r_pos[2:0]} + {1'b0, s_cnt};
    assign s_span_up = {1'b0, s_span} + (CNT_W+2)'(7);
    assign s_nb      = NB_W'(s_span_up >> 3);
    assign s_idx_ok  = r_byte_idx < s_eff;

    assign s_seek     = $signed({2'b00, r_pos}) + (POS_W+2)'(i_seek_offset);
    assign s_seek_pos = s_seek[POS_W+1] ? '0 : (s_seek[POS_W] ? {POS_W{1'b1}} : s_seek[POS_W-1:0]);

    assign s_adv     = {1'b0, r_pos} + {{(POS_W+1-CNT_W){1'b0}}, r_cnt};
    assign s_adv_pos = (s_adv > POS_SAT) ? {POS_W{1'b1}} : s_adv[POS_W-1:0];

    assign n_acc      = {r_acc[ACC_W-BYTE_W-1:0], r_rd_ok ? r_rd_data : {BYTE_W{1'b0}}};
    assign s_wide     = {{VAL_W{1'b0}}, n_acc} >> r_sh;
    assign s_mask     = (r_cnt >= CNT_W'(VAL_W)) ? {VAL_W{1'b1}}
                                                 : ((VAL_W'(1) << r_cnt) - VAL_W'(1));
    assign s_rd_value = s_wide[VAL_W-1:0] & s_mask;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && s_cmd == CMD_READ && s_cnt != '0) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (r_left == NB_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_accept = 1'b0;
        s_issue  = 1'b0;
        s_fin    = 1'b0;
        o_busy   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy   = 1'b0;
                s_accept = i_start;
            end
            S_FETCH: s_issue = 1'b1;
            S_DRAIN: s_fin   = 1'b1;
            default: o_busy  = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && s_cmd == CMD_LOAD && s_wr_idx < BUF_LEN) begin
            mem[s_wr_idx[AW-1:0]] <= i_byte_value;
        end
        if (s_issue && s_idx_ok) begin
            r_rd_data <= mem[r_byte_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_pos   <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= s_issue;
            r_done  <= 1'b0;
            if (i_cfg_wr_en) begin
                r_len <= i_cfg_wr_data;
                r_pos <= '0;
            end
            if (s_accept) begin
                unique case (s_cmd)
                    CMD_LOAD: r_done <= 1'b1;
                    CMD_SETPOS: begin
                        r_pos  <= i_new_position;
                        r_done <= 1'b1;
                    end
                    CMD_SEEK: begin
                        r_pos  <= s_seek_pos;
                        r_done <= 1'b1;
                    end
                    CMD_READ: r_done <= (s_cnt == '0);
                    default: r_done <= 1'b0;
                endcase
            end
            if (s_fin) begin
                r_pos  <= s_adv_pos;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_byte_idx <= {1'b0, r_pos[POS_W-1:3]};
            r_left     <= s_nb;
            r_sh       <= 3'(3'd0 - s_span[2:0]);
            r_cnt      <= s_cnt;
            r_acc      <= '0;
            r_value    <= '0;
            unique case (s_cmd)
                CMD_LOAD: begin
                    r_pos_out <= r_pos;
                    r_at_end  <= {1'b0, r_pos} >= s_limit;
                end
                CMD_SETPOS: begin
                    r_pos_out <= i_new_position;
                    r_at_end  <= {1'b0, i_new_position} >= s_limit;
                end
                CMD_SEEK: begin
                    r_pos_out <= s_seek_pos;
                    r_at_end  <= {1'b0, s_seek_pos} >= s_limit;
                end
                CMD_READ: begin
                    r_pos_out <= r_pos;
                    r_at_end  <= {1'b0, r_pos} >= s_limit;
                end
                default: r_pos_out <= r_pos;
            endcase
        end
        if (s_issue) begin
            r_rd_ok    <= s_idx_ok;
            r_byte_idx <= r_byte_idx + IDX_W'(1);
            r_left     <= r_left - NB_W'(1);
        end
        if (r_pend) begin
            r_acc <= n_acc;
        end
        if (s_fin) begin
            r_value   <= s_rd_value;
            r_pos_out <= s_adv_pos;
            r_at_end  <= {1'b0, s_adv_pos} >= s_limit;
        end
    end

    assign o_done         = r_done;
    assign o_read_value   = r_value;
    assign o_position_now = r_pos_out;
    assign o_at_end       = r_at_end;

    a_busy_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !o_done) else $error("result strobe while busy");

    a_short_cmd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s_cmd != CMD_READ) |=> (o_done && !o_busy))
        else $error("single-cycle command gave no result");

    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |=> o_done) else $error("read finished without result");

    a_fetch_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> (r_left != '0)) else $error("fetch with no bytes left");

    a_pos_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_position_now == r_pos)) else $error("reported position out of sync");

endmodule
